// ===== design/imusc_pkg.sv =====
// ----------------------------------------------------------------------------
// imusc_pkg
// shared types and constants of the imu bias and six-point calibration block
// ----------------------------------------------------------------------------
package imusc_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 65535;
  localparam logic [15:0] MIN_SAMPLES_RST = 16'd50;
  // 2^40 * pi / (180 * 32.8)
  localparam logic [29:0] BIAS_K          = 30'd585063966;
  localparam logic [19:0] SCALE_UNITY     = 20'd65536;
  localparam logic [19:0] SCALE_MAX       = 20'd1048575;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_COLLECT = 2'd1,
    OP_FINISH  = 2'd2,
    OP_APPLY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_ERROR  = 2'd1,
    KIND_APPLY  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR_OUT,
    ST_DIVM_GO,
    ST_DIVM_WAIT,
    ST_DIVB_GO,
    ST_DIVB_WAIT,
    ST_DIVS_GO,
    ST_DIVS_WAIT,
    ST_FIN_OUT,
    ST_APPLY_MUL,
    ST_APPLY_OUT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [1:0]         axis;
    logic               last;
    logic signed [15:0] gyro_trim;
    logic signed [31:0] gyro_bias_rad;
    logic signed [15:0] accel_mid;
    logic [19:0]        accel_gain;
    logic               axis_valid;
    logic signed [15:0] cal_x;
    logic signed [15:0] cal_y;
    logic signed [15:0] cal_z;
    logic               calibrated;
  } res_t;

  // handshake between the front queue and the back sequencer
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

// ===== design/imusc_front.sv =====
// ----------------------------------------------------------------------------
// imusc_front
// accepts input transactions, decodes the operation, two-entry queue
// ----------------------------------------------------------------------------
module imusc_front import imusc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  output queue_out_t         q_out,
  input  logic               q_pop
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      item_in;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (count != 2'd0);

  always_comb begin
    item_in.op = op_t'(operation);
    item_in.ax = accel_x;
    item_in.ay = accel_y;
    item_in.az = accel_z;
    item_in.gx = gyro_x;
    item_in.gy = gyro_y;
    item_in.gz = gyro_z;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign q_out.valid = (count != 2'd0);
  assign q_out.item  = mem[rd_ptr];

endmodule

// ===== design/imusc_div.sv =====
// ----------------------------------------------------------------------------
// imusc_div
// serial restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module imusc_div import imusc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] quo
);

  logic [63:0] shreg;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_sub;

  assign rem_sh  = {rem, shreg[63]};
  assign ge      = (rem_sh >= {1'b0, dsr});
  assign rem_sub = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      rem   <= 32'd0;
      dsr   <= den;
    end else if (busy) begin
      rem   <= ge ? rem_sub[31:0] : rem_sh[31:0];
      shreg <= {shreg[62:0], ge};
    end
  end

  assign quo = shreg[31:0];

endmodule

// ===== design/imusc_back.sv =====
// ----------------------------------------------------------------------------
// imusc_back
// executes queued operations: accumulators, finish sequencer, apply lanes
// ----------------------------------------------------------------------------
module imusc_back import imusc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  queue_out_t  q_in,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_q
);

  state_t state, state_next;

  logic [15:0]        min_samples;
  logic               collecting;
  logic [15:0]        sample_count;
  logic signed [31:0] gsum [3];
  logic signed [15:0] amin [3];
  logic signed [15:0] amax [3];
  logic               cal_valid;
  logic signed [15:0] offs [3];
  logic [19:0]        scl  [3];

  logic [1:0]         axis;
  logic [61:0]        prod;
  logic signed [15:0] goff;
  logic signed [31:0] bias;
  logic [19:0]        sc_reg;
  logic signed [15:0] raw  [3];
  logic signed [37:0] pa   [3];

  logic               div_start;
  logic [63:0]        div_num;
  logic [31:0]        div_den;
  logic               div_busy;
  logic               div_done;
  logic [31:0]        div_quo;

  logic               out_free;
  logic               out_set;
  res_t               out_d;
  logic [15:0]        need;
  logic               enough;
  logic signed [31:0] s_sel;
  logic               s_neg;
  logic [31:0]        mag;
  logic signed [16:0] range;
  logic signed [16:0] msum;
  logic               range_pos;
  logic signed [15:0] off_sel;
  logic signed [15:0] cal_lane [3];

  imusc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_free  = !out_valid || out_ready;
  assign need      = (min_samples == 16'd0) ? 16'd1 : min_samples;
  assign enough    = (sample_count >= need);
  assign s_sel     = gsum[axis];
  assign s_neg     = s_sel[31];
  assign mag       = s_neg ? 32'(-s_sel) : 32'(s_sel);
  assign range     = 17'(amax[axis]) - 17'(amin[axis]);
  assign msum      = 17'(amax[axis]) + 17'(amin[axis]);
  assign range_pos = !range[16] && (range != 17'sd0);
  assign off_sel   = range_pos ? 16'(msum >>> 1) : 16'sd0;

  always_comb begin
    logic signed [37:0] rr;
    logic signed [21:0] sh;
    for (int i = 0; i < 3; i++) begin
      rr = pa[i] + 38'sd32768;
      sh = 22'(rr >>> 16);
      if (!cal_valid)              cal_lane[i] = raw[i];
      else if (sh > 22'sd32767)    cal_lane[i] = 16'sd32767;
      else if (sh < -22'sd32768)   cal_lane[i] = -16'sd32768;
      else                         cal_lane[i] = 16'(sh);
    end
  end

  // next result register contents
  always_comb begin
    out_set = out_free && ((state == ST_ERR_OUT) || (state == ST_APPLY_OUT) ||
                           (state == ST_FIN_OUT));
    out_d            = '0;
    out_d.last       = 1'b1;
    out_d.calibrated = cal_valid;
    if (state == ST_ERR_OUT) begin
      out_d.kind = KIND_ERROR;
    end else if (state == ST_APPLY_OUT) begin
      out_d.kind  = KIND_APPLY;
      out_d.cal_x = cal_lane[0];
      out_d.cal_y = cal_lane[1];
      out_d.cal_z = cal_lane[2];
    end else begin
      out_d.kind          = KIND_REPORT;
      out_d.axis          = axis;
      out_d.last          = (axis == 2'd2);
      out_d.gyro_trim     = goff;
      out_d.gyro_bias_rad = bias;
      out_d.accel_mid     = off_sel;
      out_d.accel_gain    = sc_reg;
      out_d.axis_valid    = range_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    div_num    = {32'd0, mag};
    div_den    = {16'd0, sample_count};
    unique case (state)
      ST_IDLE: begin
        if (q_in.valid) begin
          q_pop = 1'b1;
          unique case (q_in.item.op)
            OP_FINISH: state_next = enough ? ST_DIVM_GO : ST_ERR_OUT;
            OP_APPLY:  state_next = ST_APPLY_MUL;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ERR_OUT:   if (out_free) state_next = ST_IDLE;
      ST_DIVM_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIVM_WAIT;
      end
      ST_DIVM_WAIT: if (div_done) state_next = ST_DIVB_GO;
      ST_DIVB_GO: begin
        div_start  = 1'b1;
        div_num    = 64'(prod) + 64'({sample_count, 15'd0});
        div_den    = {sample_count, 16'd0};
        state_next = ST_DIVB_WAIT;
      end
      ST_DIVB_WAIT: if (div_done) state_next = range_pos ? ST_DIVS_GO : ST_FIN_OUT;
      ST_DIVS_GO: begin
        div_start  = 1'b1;
        div_num    = 64'd1 << 29;
        div_den    = {16'd0, range[15:0]};
        state_next = ST_DIVS_WAIT;
      end
      ST_DIVS_WAIT: if (div_done) state_next = ST_FIN_OUT;
      ST_FIN_OUT:   if (out_free) state_next = (axis == 2'd2) ? ST_IDLE : ST_DIVM_GO;
      ST_APPLY_MUL: state_next = ST_APPLY_OUT;
      ST_APPLY_OUT: if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples  <= MIN_SAMPLES_RST;
      collecting   <= 1'b0;
      sample_count <= 16'd0;
      cal_valid    <= 1'b0;
      out_valid    <= 1'b0;
      axis         <= 2'd0;
    end else begin
      if (cfg_we) min_samples <= cfg_data;
      if (out_set)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        unique case (q_in.item.op)
          OP_START: begin
            cal_valid    <= 1'b0;
            sample_count <= 16'd0;
            collecting   <= 1'b1;
          end
          OP_COLLECT: begin
            if (collecting && (32'(sample_count) < MAX_SAMPLES))
              sample_count <= sample_count + 16'd1;
          end
          OP_FINISH: begin
            collecting <= 1'b0;
            axis       <= 2'd0;
            if (enough) cal_valid <= 1'b1;
          end
          default: ;
        endcase
      end
      if ((state == ST_FIN_OUT) && out_free)
        axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
    end
  end

  // accumulators and stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        gsum[i] <= 32'sd0;
        amin[i] <= 16'sd32767;
        amax[i] <= -16'sd32768;
        offs[i] <= 16'sd0;
        scl[i]  <= SCALE_UNITY;
      end
    end else begin
      if (q_pop && (q_in.item.op == OP_START)) begin
        for (int i = 0; i < 3; i++) begin
          gsum[i] <= 32'sd0;
          amin[i] <= 16'sd32767;
          amax[i] <= -16'sd32768;
        end
      end
      if (q_pop && (q_in.item.op == OP_COLLECT) && collecting &&
          (32'(sample_count) < MAX_SAMPLES)) begin
        gsum[0] <= gsum[0] + 32'(q_in.item.gx);
        gsum[1] <= gsum[1] + 32'(q_in.item.gy);
        gsum[2] <= gsum[2] + 32'(q_in.item.gz);
        if (q_in.item.ax < amin[0]) amin[0] <= q_in.item.ax;
        if (q_in.item.ay < amin[1]) amin[1] <= q_in.item.ay;
        if (q_in.item.az < amin[2]) amin[2] <= q_in.item.az;
        if (q_in.item.ax > amax[0]) amax[0] <= q_in.item.ax;
        if (q_in.item.ay > amax[1]) amax[1] <= q_in.item.ay;
        if (q_in.item.az > amax[2]) amax[2] <= q_in.item.az;
      end
      if ((state == ST_FIN_OUT) && out_free) begin
        offs[axis] <= off_sel;
        scl[axis]  <= sc_reg;
      end
    end
  end

  // datapath registers and result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      raw[0] <= q_in.item.ax;
      raw[1] <= q_in.item.ay;
      raw[2] <= q_in.item.az;
    end
    if (state == ST_DIVM_GO) prod <= mag * BIAS_K;
    if ((state == ST_DIVM_WAIT) && div_done) begin
      if (s_neg) goff <= (div_quo > 32'd32767) ? 16'sd32767 : 16'(div_quo);
      else       goff <= 16'(-$signed(17'(div_quo)));
    end
    if ((state == ST_DIVB_WAIT) && div_done) begin
      bias   <= s_neg ? -$signed(div_quo) : $signed(div_quo);
      sc_reg <= SCALE_UNITY;
    end
    if ((state == ST_DIVS_WAIT) && div_done)
      sc_reg <= (div_quo > 32'(SCALE_MAX)) ? SCALE_MAX : div_quo[19:0];
    if (state == ST_APPLY_MUL) begin
      for (int i = 0; i < 3; i++)
        pa[i] <= 38'((17'(raw[i]) - 17'(offs[i])) * $signed({1'b0, scl[i]}));
    end
    if (out_set) out_q <= out_d;
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_pop) else $error("queue popped while busy");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_q)))
    else $error("pending result overwritten");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(sample_count) <= MAX_SAMPLES) else $error("sample count past cap");

endmodule

// ===== design/imu_bias_and_six_point_calibration.sv =====
// ----------------------------------------------------------------------------
// imu_bias_and_six_point_calibration
// gyro bias averaging and six-point accelerometer offset and scale calibration
// ----------------------------------------------------------------------------
// start, collect and finish build a calibration; apply corrects accel samples.
// a front queue of two transactions takes inputs while the back sequencer is
// busy, and a result register holds the finished result until taken. start
// and collect are handled in the idle state and stream at one per cycle while
// the back is idle. apply multiplies the lanes, then rounds and saturates into
// the result register. on a successful finish, per axis the shared serial
// divider runs in turn for the gyro mean, the rad/s bias and the accel scale
// (skipped when the axis range is not positive); an unsuccessful finish goes
// through the error state. min_samples, the one register, is written through
// cfg_we / cfg_data; write it only while idle, the block does not enforce this.
module imu_bias_and_six_point_calibration import imusc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  // input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  // result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [1:0]         axis,
  output logic               last,
  output logic signed [15:0] gyro_trim,
  output logic signed [31:0] gyro_bias_rad,
  output logic signed [15:0] accel_mid,
  output logic [19:0]        accel_gain,
  output logic               axis_valid,
  output logic signed [15:0] cal_x,
  output logic signed [15:0] cal_y,
  output logic signed [15:0] cal_z,
  output logic               calibrated
);

  queue_out_t q_out;
  logic       q_pop;
  res_t       res;

  // front: accept and decode, queue between the two sides
  imusc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .gyro_x    (gyro_x),
    .gyro_y    (gyro_y),
    .gyro_z    (gyro_z),
    .q_out     (q_out),
    .q_pop     (q_pop)
  );

  // back: accumulators, finish sequencer with the divider, apply lanes
  imusc_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_in      (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_q     (res)
  );

  // result fields
  assign kind          = res.kind;
  assign axis          = res.axis;
  assign last          = res.last;
  assign gyro_trim     = res.gyro_trim;
  assign gyro_bias_rad = res.gyro_bias_rad;
  assign accel_mid     = res.accel_mid;
  assign accel_gain    = res.accel_gain;
  assign axis_valid    = res.axis_valid;
  assign cal_x         = res.cal_x;
  assign cal_y         = res.cal_y;
  assign cal_z         = res.cal_z;
  assign calibrated    = res.calibrated;

endmodule

// ===== bench/imusc_checker.sv =====
// ----------------------------------------------------------------------------
// imusc_checker
// predicts the calibration results of every input transaction and compares
// each result transaction with the oldest prediction
// ----------------------------------------------------------------------------
module imusc_checker import imusc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic  [15:0] cfg_data,
  input  logic  in_valid,
  input  logic  in_ready,
  input  item_t in_item,
  input  logic  out_valid,
  input  logic  out_ready,
  input  res_t  out_res,
  output int    n_pending,
  output int    n_fail
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] need_samples;
  bit          collecting;
  bit          cal_ok;
  int unsigned sample_cnt;
  int          gyro_acc[3];
  int          acc_lo[3];
  int          acc_hi[3];
  int          off_held[3];
  int unsigned scale_held[3];
  res_t        cal_results_q[$];

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic void clear_sums();
    sample_cnt = 0;
    for (int i = 0; i < 3; i++) begin
      gyro_acc[i] = 0;
      acc_lo[i] = 32767;
      acc_hi[i] = -32768;
    end
  endfunction

  function automatic void predict_calibration(item_t it);
    int          a[3];
    int          g[3];
    res_t        r;
    longint      s;
    longint      mean;
    longint      p;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    int          range;
    int unsigned need;
    a = '{it.ax, it.ay, it.az};
    g = '{it.gx, it.gy, it.gz};
    case (it.op)
      OP_START: begin
        cal_ok = 0;
        clear_sums();
        collecting = 1;
      end
      OP_COLLECT: begin
        if (collecting && sample_cnt < MAX_SAMPLES_DEF) begin
          for (int i = 0; i < 3; i++) begin
            gyro_acc[i] = gyro_acc[i] + g[i];
            if (a[i] < acc_lo[i]) acc_lo[i] = a[i];
            if (a[i] > acc_hi[i]) acc_hi[i] = a[i];
          end
          sample_cnt++;
        end
      end
      OP_FINISH: begin
        // a threshold of zero behaves as one
        need = (need_samples == 0) ? 1 : need_samples;
        collecting = 0;
        if (sample_cnt < need) begin
          r = '0;
          r.kind = KIND_ERROR;
          r.last = 1;
          r.calibrated = cal_ok;
          cal_results_q.push_back(r);
        end else begin
          cal_ok = 1;
          for (int i = 0; i < 3; i++) begin
            s = gyro_acc[i];
            mean = s / longint'(sample_cnt);
            mag = (s < 0) ? -s : s;
            den = longint'(sample_cnt) << 16;
            // rounded half up on the magnitude, sign put back after
            q = (mag * BIAS_K + (den >> 1)) / den;
            range = acc_hi[i] - acc_lo[i];
            r = '0;
            r.kind = KIND_REPORT;
            r.axis = 2'(i);
            r.last = (i == 2);
            r.gyro_trim = 16'(clamp16(-mean));
            r.gyro_bias_rad = 32'((s < 0) ? -q : q);
            if (range > 0) begin
              off_held[i] = (acc_hi[i] + acc_lo[i]) >>> 1;
              scale_held[i] = (32'd1 << 29) / range;
              if (scale_held[i] > SCALE_MAX) scale_held[i] = SCALE_MAX;
              r.axis_valid = 1;
            end else begin
              off_held[i] = 0;
              scale_held[i] = SCALE_UNITY;
            end
            r.accel_mid = 16'(off_held[i]);
            r.accel_gain = 20'(scale_held[i]);
            r.calibrated = 1;
            cal_results_q.push_back(r);
          end
        end
      end
      default: begin
        r = '0;
        r.kind = KIND_APPLY;
        r.last = 1;
        r.calibrated = cal_ok;
        for (int i = 0; i < 3; i++) begin
          if (cal_ok) begin
            p = longint'(a[i] - off_held[i]) * longint'(scale_held[i]);
            a[i] = clamp16((p + 32768) >>> 16);
          end
        end
        r.cal_x = 16'(a[0]);
        r.cal_y = 16'(a[1]);
        r.cal_z = 16'(a[2]);
        cal_results_q.push_back(r);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_fail++;
  endtask

  task automatic compare_result(res_t got);
    res_t w;
    if (cal_results_q.size() == 0) begin
      report_mismatch("unexpected result, kind", got.kind, -1);
      return;
    end
    w = cal_results_q.pop_front();
    if (got.kind != w.kind) report_mismatch("kind", got.kind, w.kind);
    if (got.axis != w.axis) report_mismatch("axis", got.axis, w.axis);
    if (got.last != w.last) report_mismatch("last", got.last, w.last);
    if (got.gyro_trim != w.gyro_trim)
      report_mismatch("gyro_trim", got.gyro_trim, w.gyro_trim);
    if (got.gyro_bias_rad != w.gyro_bias_rad)
      report_mismatch("gyro_bias_rad", got.gyro_bias_rad, w.gyro_bias_rad);
    if (got.accel_mid != w.accel_mid)
      report_mismatch("accel_mid", got.accel_mid, w.accel_mid);
    if (got.accel_gain != w.accel_gain)
      report_mismatch("accel_gain", got.accel_gain, w.accel_gain);
    if (got.axis_valid != w.axis_valid)
      report_mismatch("axis_valid", got.axis_valid, w.axis_valid);
    if (got.cal_x != w.cal_x) report_mismatch("cal_x", got.cal_x, w.cal_x);
    if (got.cal_y != w.cal_y) report_mismatch("cal_y", got.cal_y, w.cal_y);
    if (got.cal_z != w.cal_z) report_mismatch("cal_z", got.cal_z, w.cal_z);
    if (got.calibrated != w.calibrated)
      report_mismatch("calibrated", got.calibrated, w.calibrated);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      need_samples = MIN_SAMPLES_RST;
      collecting = 0;
      cal_ok = 0;
      clear_sums();
      for (int i = 0; i < 3; i++) begin
        off_held[i] = 0;
        scale_held[i] = SCALE_UNITY;
      end
      cal_results_q.delete();
    end else begin
      if (out_valid && out_ready) compare_result(out_res);
      if (cfg_we) need_samples = cfg_data;
      if (in_valid && in_ready) predict_calibration(in_item);
    end
    n_pending = cal_results_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives directed and random calibration sequences into the imu block, with
// random stalls on both channels; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb;
  import imusc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         operation = OP_START;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [1:0]         kind, axis;
  logic               last, axis_valid, calibrated;
  logic signed [15:0] gyro_trim, accel_mid, cal_x, cal_y, cal_z;
  logic signed [31:0] gyro_bias_rad;
  logic [19:0]        accel_gain;

  item_t in_item;
  res_t  out_res;
  int    n_pending, n_fail;
  // no idling on either side once set
  bit    quiet = 0;
  int    stall_left = 0;

  // 10 ns clock
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  imu_bias_and_six_point_calibration u_top (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_valid, .in_ready, .operation,
    .accel_x, .accel_y, .accel_z, .gyro_x, .gyro_y, .gyro_z,
    .out_valid, .out_ready, .kind, .axis, .last,
    .gyro_trim, .gyro_bias_rad, .accel_mid, .accel_gain, .axis_valid,
    .cal_x, .cal_y, .cal_z, .calibrated
  );

  assign in_item = {operation, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z};
  assign out_res = {kind, axis, last, gyro_trim, gyro_bias_rad, accel_mid,
                    accel_gain, axis_valid, cal_x, cal_y, cal_z, calibrated};

  imusc_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_res, .n_pending, .n_fail
  );

  // result side backpressure: random stall bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // one input transaction; valid stays up into the next one unless a gap comes
  task automatic send(op_t op, int ax, int ay, int az, int gx, int gy, int gz);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1;
    operation <= op;
    accel_x <= 16'(ax); accel_y <= 16'(ay); accel_z <= 16'(az);
    gyro_x <= 16'(gx);  gyro_y <= 16'(gy);  gyro_z <= 16'(gz);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_op(op_t op);
    send(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // drain, let any silent transaction settle, then write the threshold
  task automatic set_min_samples(logic [15:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we   <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // accel near one of six gravity orientations, gyro near a fixed bias
  task automatic send_still_sample(int face, int gbias);
    int a[3];
    for (int i = 0; i < 3; i++) a[i] = $urandom_range(0, 400) - 200;
    a[face % 3] += (face < 3) ? 4096 : -4096;
    if ($urandom_range(0, 15) == 0) a[$urandom_range(0, 2)] = $urandom;
    send(OP_COLLECT, a[0], a[1], a[2],
         gbias + $urandom_range(0, 40) - 20, -gbias + $urandom_range(0, 40) - 20,
         ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8) - 4);
  endtask

  initial begin
    int n;
    int gb;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: lowest threshold, extremes and special cases
    set_min_samples(16'd1);
    send(OP_APPLY, 32767, -32768, 0, 0, 0, 0);         // uncalibrated pass-through
    send(OP_FINISH, 0, 0, 0, 0, 0, 0);                 // no samples: error
    send(OP_COLLECT, 1, 2, 3, 4, 5, 6);                // ignored, not collecting
    send(OP_START, 0, 0, 0, 0, 0, 0);
    send(OP_COLLECT, 32767, 32767, 32767, -32768, 32767, -32768);
    send(OP_COLLECT, -32768, -32768, -32768, -32768, 32767, -32768);
    send(OP_FINISH, 0, 0, 0, 0, 0, 0);                 // full range, saturated gyro offset
    send(OP_APPLY, 32767, -32768, -1, 0, 0, 0);
    send(OP_FINISH, 0, 0, 0, 0, 0, 0);                 // repeated finish reports again
    send(OP_START, 0, 0, 0, 0, 0, 0);
    send(OP_COLLECT, 100, -4096, 4096, 7, -7, 0);      // one sample: zero ranges
    send(OP_FINISH, 0, 0, 0, 0, 0, 0);
    send(OP_APPLY, -32768, 32767, 100, 0, 0, 0);
    send(OP_START, 0, 0, 0, 0, 0, 0);
    send(OP_COLLECT, 0, 0, 0, 3, -3, 1);
    send(OP_COLLECT, 1, 2, 2, 2, -2, 0);               // tiny ranges: scale saturates
    send(OP_FINISH, 0, 0, 0, 0, 0, 0);
    send(OP_APPLY, 32767, -32768, 2, 0, 0, 0);

    // highest threshold: too few samples gives an error and leaves the block uncalibrated
    set_min_samples(16'd65535);
    send(OP_START, 0, 0, 0, 0, 0, 0);
    send(OP_COLLECT, 4096, 0, 0, 10, 10, 10);
    send(OP_FINISH, 0, 0, 0, 0, 0, 0);
    send(OP_APPLY, 4096, 0, -4096, 0, 0, 0);

    // random calibration runs under several thresholds
    for (int ph = 0; ph < 4; ph++) begin
      set_min_samples((ph == 0) ? 16'd50 : 16'($urandom_range(1, 12)));
      for (int run = 0; run < ((ph == 0) ? 1 : 3); run++) begin
        if (ph == 3 && run == 2) quiet = 1;
        gb = $urandom_range(0, 600) - 300;
        send(OP_START, 0, 0, 0, 0, 0, 0);
        n = (ph == 0) ? $urandom_range(45, 60) : $urandom_range(0, 18);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 19) == 0) send_op(op_t'($urandom_range(0, 3)));
          else send_still_sample(k % 6, gb);
        end
        send(OP_FINISH, 0, 0, 0, 0, 0, 0);
        repeat ($urandom_range(1, 5)) send_op(OP_APPLY);
      end
    end

    in_valid <= 0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_fail == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // overall limit
  initial begin
    #30ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
